// File: rtl/mcms_pkg.sv
package mcms_pkg;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_CLEAR     = 2'd1,
        CMD_CLEAR_ALL = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    // Work decided at the front for each request, finished at the result stage.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_FILL      = 3'd1,
        OP_SLOPE     = 3'd2,
        OP_READ      = 3'd3,
        OP_CLEAR_ONE = 3'd4,
        OP_CLEAR_ALL = 3'd5
    } t_op;

    // Wide enough for the largest supported channel count.
    localparam int CH_IDX_W = 6;

    // Reset value of the fill slope register, Q16.16 (about 0.002).
    localparam logic signed [31:0] FILL_SLOPE_RST = 32'sd131;

    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         channel;
        logic signed [31:0] sample_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] slope;
        logic               window_full;
    } t_out;

    // Control that follows a request down the pipeline.
    typedef struct packed {
        t_op                 op;
        logic [CH_IDX_W-1:0] ch;
        logic                full;
    } t_ctl;

    // First pipeline stage as seen by the rest of the block.
    typedef struct packed {
        logic               valid;
        t_ctl               ctl;
        logic signed [31:0] sample;
    } t_s1;

endpackage

// File: rtl/multi_channel_moving_slope_unit.sv
// Path: a request passes the first stage register, two divider stages and the result register.
// Throughput: one request per cycle; the front, two divider stages and the
// result register move together and hold whenever a result waits to be taken.
// Reset: synchronous, active low; clears fill counts, ring positions, stored
// slopes and pipeline valids, and loads fill_slope with 131. The sample ring
// memory is not cleared; an entry is only used for a slope after it has been written.
module multi_channel_moving_slope_unit import mcms_pkg::*; #(
    parameter int WINDOW   = 16,
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic               w_adv;
    logic               w_accept;
    t_s1                w_s1;
    logic [31:0]        w_old;
    logic signed [31:0] w_quot;

    logic               r_ca_valid;
    t_ctl               r_ca;
    logic               r_cb_valid;
    t_ctl               r_cb;
    logic               r_out_valid;
    t_out               r_out;
    logic signed [31:0] r_fill_slope;
    logic signed [31:0] r_slope [CHANNELS];

    logic [CW-1:0]      w_cidx;
    t_out               n_out;
    logic               w_st_we;
    logic signed [31:0] w_st_val;
    logic               w_st_clr_all;

    // The whole pipeline advances when the result register is free or drained.
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && w_adv;
    assign o_in_ready = w_adv;

    mcms_front #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_adv    (w_adv),
        .i_in     (i_in_data),
        .o_s1     (w_s1),
        .o_old    (w_old)
    );

    mcms_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_new  (w_s1.sample),
        .i_old  (w_old),
        .o_quot (w_quot)
    );

    // Fill slope configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_slope <= FILL_SLOPE_RST;
        end else if (i_cfg_we) begin
            r_fill_slope <= i_cfg_wdata;
        end
    end

    // Control travels alongside the two divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca_valid <= 1'b0;
            r_cb_valid <= 1'b0;
        end else if (w_adv) begin
            r_ca_valid <= w_s1.valid;
            r_cb_valid <= r_ca_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ca <= w_s1.ctl;
            r_cb <= r_ca;
        end
    end

    assign w_cidx = r_cb.ch[CW-1:0];

    // Finish the request: pick the slope and the slope store update.
    always_comb begin
        n_out.slope       = '0;
        n_out.window_full = r_cb.full;
        w_st_we           = 1'b0;
        w_st_val          = '0;
        w_st_clr_all      = 1'b0;
        case (r_cb.op)
            OP_FILL: begin
                n_out.slope = r_fill_slope;
                w_st_we     = 1'b1;
                w_st_val    = r_fill_slope;
            end
            OP_SLOPE: begin
                n_out.slope = w_quot;
                w_st_we     = 1'b1;
                w_st_val    = w_quot;
            end
            OP_READ: begin
                n_out.slope = r_slope[w_cidx];
            end
            OP_CLEAR_ONE: begin
                w_st_we = 1'b1;
            end
            OP_CLEAR_ALL: begin
                w_st_clr_all = 1'b1;
            end
            default: begin
                n_out.slope = '0;
            end
        endcase
    end

    // Per-channel slope store, updated in request order at the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_slope[c] <= '0;
            end
        end else if (w_adv && r_cb_valid) begin
            if (w_st_clr_all) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_slope[c] <= '0;
                end
            end else if (w_st_we) begin
                r_slope[w_cidx] <= w_st_val;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_cb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // An accepted request always lands in the first stage.
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_s1.valid)
        else $error("accepted request missing from first stage");

    // A computed slope only happens on a channel with a full window.
    a_slope_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cb_valid && (r_cb.op == OP_SLOPE)) |-> r_cb.full)
        else $error("slope computed on a partial window");

    // Clears and ignored requests never report a full window.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cb_valid && ((r_cb.op == OP_CLEAR_ONE) || (r_cb.op == OP_CLEAR_ALL) ||
                        (r_cb.op == OP_NONE))) |-> !r_cb.full)
        else $error("clear or ignored request reports a full window");

    // With the result register empty the block must take a request.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused while result register is empty");
`endif

endmodule

// File: rtl/mcms_front.sv
module mcms_front import mcms_pkg::*; #(
    parameter int WINDOW   = 16,
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_adv,
    input  t_in         i_in,
    output t_s1         o_s1,
    output logic [31:0] o_old
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNTW  = $clog2(WINDOW + 1);
    localparam int AW    = CW + PW;
    localparam int DEPTH = CHANNELS << PW;

    logic [CNTW-1:0]    r_cnt [CHANNELS];
    logic [PW-1:0]      r_pos [CHANNELS];
    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_old;
    logic               r_s1_valid;
    t_ctl               r_s1_ctl;
    logic signed [31:0] r_s1_smp;

    logic [CW-1:0]   w_idx;
    logic            w_ch_ok;
    logic [CNTW-1:0] w_cur_cnt;
    logic [PW-1:0]   w_cur_pos;
    logic            w_was_full;
    logic [CNTW-1:0] n_cnt;
    logic [PW-1:0]   n_pos;
    logic [AW-1:0]   w_addr;
    logic            w_wr;
    logic            w_clr_one;
    logic            w_clr_all;
    t_ctl            n_ctl;

    assign w_idx      = CW'(i_in.channel);
    assign w_ch_ok    = (32'(i_in.channel) < 32'(CHANNELS));
    assign w_cur_cnt  = r_cnt[w_idx];
    assign w_cur_pos  = r_pos[w_idx];
    assign w_was_full = (w_cur_cnt == CNTW'(WINDOW));
    assign w_addr     = {w_idx, w_cur_pos};

    // Count saturates at a full window; the ring position wraps at WINDOW.
    assign n_cnt = w_was_full ? w_cur_cnt : w_cur_cnt + CNTW'(1);
    assign n_pos = (w_cur_pos == PW'(WINDOW - 1)) ? '0 : w_cur_pos + PW'(1);

    // Decode the request into its channel update and the pipeline operation.
    always_comb begin
        w_wr      = 1'b0;
        w_clr_one = 1'b0;
        w_clr_all = 1'b0;
        n_ctl     = '{op: OP_NONE, ch: CH_IDX_W'(i_in.channel), full: 1'b0};
        if (i_in.cmd == CMD_CLEAR_ALL) begin
            w_clr_all = 1'b1;
            n_ctl.op  = OP_CLEAR_ALL;
        end else if (w_ch_ok) begin
            unique case (i_in.cmd)
                CMD_CLEAR: begin
                    w_clr_one = 1'b1;
                    n_ctl.op  = OP_CLEAR_ONE;
                end
                CMD_SAMPLE: begin
                    w_wr       = 1'b1;
                    n_ctl.op   = w_was_full ? OP_SLOPE : OP_FILL;
                    n_ctl.full = (n_cnt == CNTW'(WINDOW));
                end
                CMD_READ: begin
                    n_ctl.op   = OP_READ;
                    n_ctl.full = w_was_full;
                end
                default: begin
                    n_ctl.op = OP_NONE;
                end
            endcase
        end
    end

    // Per-channel fill count and ring position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c] <= '0;
                r_pos[c] <= '0;
            end
        end else if (i_accept) begin
            if (w_clr_all) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_cnt[c] <= '0;
                    r_pos[c] <= '0;
                end
            end else if (w_clr_one) begin
                r_cnt[w_idx] <= '0;
                r_pos[w_idx] <= '0;
            end else if (w_wr) begin
                r_cnt[w_idx] <= n_cnt;
                r_pos[w_idx] <= n_pos;
            end
        end
    end

    // Sample ring memory: the old entry is read in the same cycle it is replaced.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_old <= r_mem[w_addr];
        end
        if (i_accept && w_wr) begin
            r_mem[w_addr] <= i_in.sample_value;
        end
    end

    // First stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_ctl <= n_ctl;
            r_s1_smp <= i_in.sample_value;
        end
    end

    assign o_s1  = '{valid: r_s1_valid, ctl: r_s1_ctl, sample: r_s1_smp};
    assign o_old = r_old;

endmodule

// File: rtl/mcms_div.sv
module mcms_div import mcms_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic signed [31:0] i_new,
    input  logic signed [31:0] i_old,
    output logic signed [31:0] o_quot
);

    localparam bit IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

    logic [32:0] w_fwd;
    logic [32:0] w_rev;
    logic [32:0] r_mag;
    logic        r_neg;
    logic        r_neg_b;
    logic [32:0] w_q;
    logic [33:0] w_sv;

    // Both differences side by side; the sign of one picks the magnitude.
    assign w_fwd = {i_new[31], i_new} - {i_old[31], i_old};
    assign w_rev = {i_old[31], i_old} - {i_new[31], i_new};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg <= w_fwd[32];
            r_mag <= w_fwd[32] ? w_rev : w_fwd;
        end
    end

    generate
        if (IS_POW2) begin : g_shift
            localparam int LOG = $clog2(WINDOW);
            logic [32:0] r_q;

            // Division by a power of two is a plain shift of the magnitude.
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_q     <= r_mag >> LOG;
                    r_neg_b <= r_neg;
                end
            end

            assign w_q = r_q;
        end else begin : g_recip
            localparam logic [31:0] RECIP = 32'((64'd1 << 33) / 64'(WINDOW));
            localparam logic [8:0]  WIN   = 9'(WINDOW);
            logic [64:0] w_prod;
            logic [31:0] r_est;
            logic [32:0] r_mag_b;
            logic [40:0] w_back;
            logic [40:0] w_rem;

            // Reciprocal estimate, at most one below the true quotient.
            assign w_prod = r_mag * RECIP;

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_est   <= w_prod[64:33];
                    r_mag_b <= r_mag;
                    r_neg_b <= r_neg;
                end
            end

            // One compare and step fixes the estimate.
            assign w_back = r_est * WIN;
            assign w_rem  = {8'd0, r_mag_b} - w_back;
            assign w_q    = (w_rem >= 41'(WINDOW)) ? 33'(r_est) + 33'd1 : 33'(r_est);
        end
    endgenerate

    // Restore the sign (truncation toward zero) and saturate to 32 bits.
    assign w_sv = r_neg_b ? -{1'b0, w_q} : {1'b0, w_q};

    always_comb begin
        if ((w_sv[33:31] == 3'b000) || (w_sv[33:31] == 3'b111)) begin
            o_quot = w_sv[31:0];
        end else if (w_sv[33]) begin
            o_quot = 32'sh8000_0000;
        end else begin
            o_quot = 32'sh7FFF_FFFF;
        end
    end

endmodule
